[sv/dmxr_pkg.sv]
// Shared constants, codes and types of the multi-universe DMX receiver.
package dmxr_pkg;

  localparam int unsigned MAX_UNIVERSES_DEF      = 32;
  localparam int unsigned SLOTS_PER_UNIVERSE_DEF = 512;
  localparam int unsigned CHANNEL_MAX            = 512;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0] SEQ_RESET = 8'hFF;

  localparam int unsigned RES_FIFO_DEPTH = 3;
  localparam int unsigned RES_CNT_W      = $clog2(RES_FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_UNIVERSE = 3'd0,
    CFG_UNIVERSE_COUNT = 3'd1,
    CFG_CHANNEL_COUNT  = 3'd2,
    CFG_SYNC_ENABLE    = 3'd3,
    CFG_OUTPUT_MODE    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OUT_UPDATE    = 3'd0,
    OUT_BANG      = 3'd1,
    OUT_AUTOMATIC = 3'd2,
    OUT_CHANGE    = 3'd3,
    OUT_FORCED    = 3'd4
  } out_mode_e;

  localparam logic ITEM_SLOT = 1'b0;
  localparam logic ITEM_READ = 1'b1;

  localparam logic RESULT_NOTIFY = 1'b0;
  localparam logic RESULT_READ   = 1'b1;

  typedef struct packed {
    logic [7:0] store;
    logic [7:0] snapshot;
  } slot_entry_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       in_range;
  } result_t;

endpackage

[sv/dmxr_seq_table.sv]
// Sequence number table with per-entry valid bits and write forwarding.
module dmxr_seq_table #(
  parameter int unsigned IDX_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output logic [7:0]       rd_seq_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  logic [7:0]       wr_seq_i
);
  import dmxr_pkg::*;

  localparam int unsigned DEPTH = 2 ** IDX_W;

  logic [7:0]       mem [DEPTH];
  logic [7:0]       rd_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [DEPTH-1:0] valid_q;
  logic             fwd_valid_q;
  logic [IDX_W-1:0] fwd_idx_q;
  logic [7:0]       fwd_seq_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_seq_i;
    end
    if (rd_en_i) begin
      rd_q     <= mem[rd_idx_i];
      rd_idx_q <= rd_idx_i;
    end
    fwd_idx_q <= wr_idx_i;
    fwd_seq_q <= wr_seq_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= wr_en_i;
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  always_comb begin
    if (!valid_q[rd_idx_q]) begin
      rd_seq_o = SEQ_RESET;
    end else if (fwd_valid_q && (fwd_idx_q == rd_idx_q)) begin
      rd_seq_o = fwd_seq_q;
    end else begin
      rd_seq_o = rd_q;
    end
  end

endmodule

[sv/dmxr_slot_store.sv]
// Slot store and output snapshot memory with clearing pass and write forwarding.
module dmxr_slot_store #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 busy_o,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output dmxr_pkg::slot_entry_t rd_entry_o,
  input  logic                 wr_en_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  dmxr_pkg::slot_entry_t wr_entry_i
);
  import dmxr_pkg::*;

  slot_entry_t mem [DEPTH];
  slot_entry_t rd_q;
  logic [AW-1:0] rd_addr_q;
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  slot_entry_t   fwd_entry_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;

  assign busy_o    = clr_busy_q;
  assign mem_we    = clr_busy_q || wr_en_i;
  assign mem_waddr = clr_busy_q ? clr_addr_q : wr_addr_i;
  assign mem_wdata = clr_busy_q ? slot_entry_t'('0) : wr_entry_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
    fwd_addr_q  <= wr_addr_i;
    fwd_entry_q <= wr_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= wr_en_i && !clr_busy_q;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  assign rd_entry_o = (fwd_valid_q && (fwd_addr_q == rd_addr_q)) ? fwd_entry_q : rd_q;

endmodule

[sv/dmxr_result_fifo.sv]
// Small result queue between the update stage and the output channel.
module dmxr_result_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  dmxr_pkg::result_t              push_data_i,
  output logic [dmxr_pkg::RES_CNT_W-1:0] count_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dmxr_pkg::result_t              out_data_o
);
  import dmxr_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_FIFO_DEPTH);

  result_t              buf_q [RES_FIFO_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q;
  logic [PTR_W-1:0]     rd_ptr_q;
  logic [RES_CNT_W-1:0] cnt_q;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(RES_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(RES_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + RES_CNT_W'(1);
      end else if (!push_i && pop) begin
        cnt_q <= cnt_q - RES_CNT_W'(1);
      end
    end
  end

endmodule

[sv/dmx_multi_universe_receiver_top.sv]
// Top level of the multi-universe DMX receiver: registers, window logic and update stage.
//
//   Channel  Direction  Handshake            Payload
//   cfg      in         cfg_we_i             cfg_index_i, cfg_data_i
//   in       in         in_valid_i/ready_o   mode, universe, sequence, slot fields, read address
//   out      out        out_valid_o/ready_i  result_kind, read_value, read_in_range
//
// One item per cycle when not stalled: both memories are read in the cycle an item is
// taken, the update stage writes back from its s1 registers and queues any result. After
// reset the slot memory is cleared in a pass over all MAX_UNIVERSES * SLOTS_PER_UNIVERSE
// entries (16384 by default), during which no item is taken; configuration writes still
// are. Else the input stalls only when the three-entry result queue could overflow.
module dmx_multi_universe_receiver_top #(
  parameter int unsigned MAX_UNIVERSES      = dmxr_pkg::MAX_UNIVERSES_DEF,
  parameter int unsigned SLOTS_PER_UNIVERSE = dmxr_pkg::SLOTS_PER_UNIVERSE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dmxr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dmxr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [15:0]                     universe_number_i,
  input  logic [7:0]                      sequence_number_i,
  input  logic [8:0]                      slot_index_i,
  input  logic [7:0]                      slot_value_i,
  input  logic                            slot_present_i,
  input  logic                            packet_first_i,
  input  logic                            packet_last_i,
  input  logic [13:0]                     read_address_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            result_kind_o,
  output logic [7:0]                      read_value_o,
  output logic                            read_in_range_o
);
  import dmxr_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_UNIVERSES * SLOTS_PER_UNIVERSE;
  localparam int unsigned IDX_W = (MAX_UNIVERSES > 1) ? $clog2(MAX_UNIVERSES) : 1;
  localparam int unsigned SA_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned DC_W  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CNT_W = $clog2(MAX_UNIVERSES + 1);

  logic [15:0] first_universe_q;
  logic [5:0]  universe_count_q;
  logic [9:0]  channel_count_q;
  logic        sync_enable_q;
  logic [2:0]  output_mode_q;

  logic [15:0]      eff_first;
  logic [CNT_W-1:0] eff_count;
  logic [9:0]       eff_chan;
  logic [31:0]      total_slots;
  logic [MAX_UNIVERSES-1:0] all_mask;
  logic             window_clear;

  logic                     packet_accepted_q;
  logic [IDX_W-1:0]         current_index_q;
  logic [DC_W-1:0]          dc_q;
  logic [MAX_UNIVERSES-1:0] flags_q;

  logic                     acc_d;
  logic [IDX_W-1:0]         current_index_d;
  logic [DC_W-1:0]          dc_d;
  logic [MAX_UNIVERSES-1:0] flags_d;

  logic             s1_valid_q;
  logic             s1_read_q;
  logic             s1_first_q;
  logic             s1_last_q;
  logic             s1_present_q;
  logic             s1_slot_ok_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_idx_ok_q;
  logic [7:0]       s1_seq_q;
  logic [7:0]       s1_value_q;
  logic             s1_rd_ok_q;
  logic             s1_in_range_q;
  logic [SA_W-1:0]  s1_addr_q;

  logic             accept;
  logic [15:0]      win_idx;
  logic             idx_ok;
  logic [IDX_W-1:0] src_idx;
  logic [31:0]      slot_lin;
  logic [31:0]      read_lin;
  logic [SA_W-1:0]  st_rd_addr;

  logic             store_busy;
  slot_entry_t      ent;
  logic             st_we;
  slot_entry_t      st_wentry;
  logic [7:0]       seq_rd;
  logic             seq_we;

  logic                 push;
  result_t              push_res;
  result_t              out_res;
  logic [RES_CNT_W-1:0] fifo_cnt;
  logic                 notify;

  always_comb begin
    eff_first = (first_universe_q == 16'd0) ? 16'd1 : first_universe_q;
    if (universe_count_q == 6'd0) begin
      eff_count = CNT_W'(1);
    end else if (32'(universe_count_q) > MAX_UNIVERSES) begin
      eff_count = CNT_W'(MAX_UNIVERSES);
    end else begin
      eff_count = CNT_W'(universe_count_q);
    end
    if (channel_count_q == 10'd0) begin
      eff_chan = 10'd1;
    end else if (32'(channel_count_q) > CHANNEL_MAX) begin
      eff_chan = 10'(CHANNEL_MAX);
    end else begin
      eff_chan = channel_count_q;
    end
    if (32'(eff_chan) > SLOTS_PER_UNIVERSE) begin
      total_slots = 32'(SLOTS_PER_UNIVERSE) * 32'(eff_count);
    end else begin
      total_slots = 32'(eff_chan) * 32'(eff_count);
    end
    for (int i = 0; i < MAX_UNIVERSES; i++) begin
      all_mask[i] = (i < int'(eff_count));
    end
  end

  assign window_clear = cfg_we_i && ((cfg_index_i == CFG_FIRST_UNIVERSE) ||
                                     (cfg_index_i == CFG_UNIVERSE_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_universe_q <= 16'd1;
      universe_count_q <= 6'd1;
      channel_count_q  <= 10'd512;
      sync_enable_q    <= 1'b1;
      output_mode_q    <= OUT_UPDATE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FIRST_UNIVERSE: first_universe_q <= cfg_data_i[15:0];
        CFG_UNIVERSE_COUNT: universe_count_q <= cfg_data_i[5:0];
        CFG_CHANNEL_COUNT:  channel_count_q  <= cfg_data_i[9:0];
        CFG_SYNC_ENABLE:    sync_enable_q    <= cfg_data_i[0];
        CFG_OUTPUT_MODE:    output_mode_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !store_busy &&
                      ((32'(fifo_cnt) + 32'(s1_valid_q)) < RES_FIFO_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    win_idx    = universe_number_i - eff_first;
    idx_ok     = 32'(win_idx) < 32'(eff_count);
    src_idx    = packet_first_i ? win_idx[IDX_W-1:0] : current_index_d;
    slot_lin   = 32'(src_idx) * 32'(SLOTS_PER_UNIVERSE) + 32'(slot_index_i);
    read_lin   = 32'(read_address_i);
    st_rd_addr = (mode_i == ITEM_READ) ? read_lin[SA_W-1:0] : slot_lin[SA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q     <= (mode_i == ITEM_READ);
      s1_first_q    <= packet_first_i;
      s1_last_q     <= packet_last_i;
      s1_present_q  <= slot_present_i;
      s1_slot_ok_q  <= 32'(slot_index_i) < SLOTS_PER_UNIVERSE;
      s1_idx_q      <= win_idx[IDX_W-1:0];
      s1_idx_ok_q   <= idx_ok;
      s1_seq_q      <= sequence_number_i;
      s1_value_q    <= slot_value_i;
      s1_rd_ok_q    <= read_lin < STORE_DEPTH;
      s1_in_range_q <= read_lin < total_slots;
      s1_addr_q     <= st_rd_addr;
    end
  end

  dmxr_seq_table #(
    .IDX_W(IDX_W)
  ) u_seq_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (window_clear),
    .rd_en_i (accept),
    .rd_idx_i(win_idx[IDX_W-1:0]),
    .rd_seq_o(seq_rd),
    .wr_en_i (seq_we),
    .wr_idx_i(s1_idx_q),
    .wr_seq_i(s1_seq_q)
  );

  dmxr_slot_store #(
    .DEPTH(STORE_DEPTH),
    .AW   (SA_W)
  ) u_slot_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (store_busy),
    .rd_en_i   (accept),
    .rd_addr_i (st_rd_addr),
    .rd_entry_o(ent),
    .wr_en_i   (st_we),
    .wr_addr_i (s1_addr_q),
    .wr_entry_i(st_wentry)
  );

  always_comb begin
    acc_d           = packet_accepted_q;
    current_index_d = current_index_q;
    dc_d            = dc_q;
    flags_d         = flags_q;
    seq_we          = 1'b0;
    st_we           = 1'b0;
    st_wentry       = ent;
    push            = 1'b0;
    push_res        = '0;
    notify          = 1'b0;
    if (s1_valid_q) begin
      if (s1_read_q) begin
        push              = 1'b1;
        push_res.kind     = RESULT_READ;
        push_res.value    = s1_rd_ok_q ? ent.store : 8'd0;
        push_res.in_range = s1_in_range_q;
        if (s1_rd_ok_q) begin
          st_we              = 1'b1;
          st_wentry.snapshot = ent.store;
          if (ent.store != ent.snapshot) begin
            dc_d = dc_q - DC_W'(1);
          end
        end
      end else begin
        if (s1_first_q) begin
          acc_d = s1_idx_ok_q && (s1_seq_q != seq_rd);
          if (acc_d) begin
            seq_we          = 1'b1;
            current_index_d = s1_idx_q;
          end
        end
        if (acc_d) begin
          if (s1_present_q && s1_slot_ok_q) begin
            st_we           = 1'b1;
            st_wentry.store = s1_value_q;
            if ((ent.store != ent.snapshot) && (s1_value_q == ent.snapshot)) begin
              dc_d = dc_q - DC_W'(1);
            end else if ((ent.store == ent.snapshot) && (s1_value_q != ent.snapshot)) begin
              dc_d = dc_q + DC_W'(1);
            end
          end
          if (s1_last_q) begin
            acc_d  = 1'b0;
            notify = 1'b1;
            if (sync_enable_q && (eff_count > CNT_W'(1))) begin
              flags_d[current_index_d] = 1'b1;
              if ((flags_d & all_mask) != all_mask) begin
                notify = 1'b0;
              end else begin
                flags_d = '0;
              end
            end
            if (notify && ((output_mode_q == OUT_UPDATE) || (output_mode_q == OUT_AUTOMATIC) ||
                           ((output_mode_q == OUT_CHANGE) && (dc_d != '0)))) begin
              push          = 1'b1;
              push_res.kind = RESULT_NOTIFY;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      packet_accepted_q <= 1'b0;
      current_index_q   <= '0;
      dc_q              <= '0;
      flags_q           <= '0;
    end else begin
      dc_q <= dc_d;
      if (window_clear) begin
        packet_accepted_q <= 1'b0;
        current_index_q   <= '0;
        flags_q           <= '0;
      end else begin
        packet_accepted_q <= acc_d;
        current_index_q   <= current_index_d;
        flags_q           <= flags_d;
      end
    end
  end

  dmxr_result_fifo u_result_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_res),
    .count_o    (fifo_cnt),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_res)
  );

  assign result_kind_o   = out_res.kind;
  assign read_value_o    = out_res.value;
  assign read_in_range_o = out_res.in_range;

endmodule

[sim/tb_dmx_multi_universe_receiver_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the multi-universe DMX receiver: directed and random packet and read traffic.
module tb_dmx_multi_universe_receiver_top;
  import dmxr_pkg::*;

  localparam int unsigned STORE_DEPTH  = MAX_UNIVERSES_DEF * SLOTS_PER_UNIVERSE_DEF;
  localparam int unsigned STALL_LIMIT  = 50000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [2:0]  MODE_CODE_5  = 3'd5;
  localparam logic [2:0]  MODE_CODE_7  = 3'd7;

  typedef struct {
    logic        mode;
    logic [15:0] uni;
    logic [7:0]  seq;
    logic [8:0]  slot;
    logic [7:0]  val;
    logic        present;
    logic        first;
    logic        last;
    logic [13:0] addr;
  } dmx_item_t;

  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i        = '0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_ready_o;
  logic                  mode_i            = 1'b0;
  logic [15:0]           universe_number_i = '0;
  logic [7:0]            sequence_number_i = '0;
  logic [8:0]            slot_index_i      = '0;
  logic [7:0]            slot_value_i      = '0;
  logic                  slot_present_i    = 1'b0;
  logic                  packet_first_i    = 1'b0;
  logic                  packet_last_i     = 1'b0;
  logic [13:0]           read_address_i    = '0;
  logic                  out_valid_o;
  logic                  out_ready_i       = 1'b0;
  logic                  result_kind_o;
  logic [7:0]            read_value_o;
  logic                  read_in_range_o;

  dmx_multi_universe_receiver_top uut (.*);

  // Receiver model state and its copy of the registers.
  logic [7:0]  slot_mem [STORE_DEPTH];
  logic [7:0]  snap_mem [STORE_DEPTH];
  logic [7:0]  last_seq [MAX_UNIVERSES_DEF];
  logic [7:0]  sent_seq [MAX_UNIVERSES_DEF];
  logic [31:0] uni_seen;
  int unsigned dirty_count;
  bit          pkt_open;
  int unsigned pkt_uni;
  logic [15:0] reg_first;
  logic [5:0]  reg_count;
  logic [9:0]  reg_chans;
  logic        reg_sync;
  logic [2:0]  reg_mode;

  dmx_item_t   packet_item_q[$];
  result_t     notify_read_q[$];
  dmx_item_t   drv_item;
  result_t     awaited;
  bit          beat_taken;
  bit          progress;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_left;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned items_made;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_first();
    return (reg_first == 16'd0) ? 1 : reg_first;
  endfunction

  function automatic int unsigned eff_count();
    if (reg_count == 6'd0) return 1;
    if (reg_count > MAX_UNIVERSES_DEF) return MAX_UNIVERSES_DEF;
    return reg_count;
  endfunction

  function automatic int unsigned eff_chans();
    if (reg_chans == 10'd0) return 1;
    if (reg_chans > CHANNEL_MAX) return CHANNEL_MAX;
    return reg_chans;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < MAX_UNIVERSES_DEF; i++) begin
      last_seq[i] = SEQ_RESET;
      sent_seq[i] = SEQ_RESET;
    end
    uni_seen = '0;
    pkt_open = 1'b0;
    pkt_uni  = 0;
  endfunction

  task automatic absorb_item(input dmx_item_t it);
    int unsigned cnt;
    int unsigned idx;
    int unsigned a;
    logic [31:0] diff;
    logic [31:0] all_mask;
    bit          was;
    bit          due;
    result_t     res;
    cnt = eff_count();
    if (it.mode == ITEM_READ) begin
      a = it.addr;
      res.kind     = RESULT_READ;
      res.value    = slot_mem[a];
      res.in_range = (a < eff_chans() * cnt);
      if (slot_mem[a] != snap_mem[a]) dirty_count--;
      snap_mem[a] = slot_mem[a];
      notify_read_q.insert(notify_read_q.size(), res);
    end else begin
      if (it.first) begin
        diff = {16'd0, it.uni} - eff_first();
        idx  = diff[15:0];
        pkt_open = 1'b0;
        if (idx < cnt && it.seq != last_seq[idx]) begin
          last_seq[idx] = it.seq;
          pkt_uni  = idx;
          pkt_open = 1'b1;
        end
      end
      if (pkt_open) begin
        if (it.present) begin
          a   = pkt_uni * SLOTS_PER_UNIVERSE_DEF + it.slot;
          was = (slot_mem[a] != snap_mem[a]);
          slot_mem[a] = it.val;
          if (was && slot_mem[a] == snap_mem[a]) dirty_count--;
          if (!was && slot_mem[a] != snap_mem[a]) dirty_count++;
        end
        if (it.last) begin
          pkt_open = 1'b0;
          due = 1'b1;
          if (reg_sync && cnt > 1) begin
            all_mask = (cnt >= 32) ? 32'hFFFF_FFFF : ((32'd1 << cnt) - 32'd1);
            uni_seen = uni_seen | (32'd1 << pkt_uni);
            if ((uni_seen & all_mask) != all_mask) due = 1'b0;
            else uni_seen = '0;
          end
          if (due && (reg_mode == OUT_UPDATE || reg_mode == OUT_AUTOMATIC ||
                      (reg_mode == OUT_CHANGE && dirty_count != 0))) begin
            res.kind     = RESULT_NOTIFY;
            res.value    = 8'd0;
            res.in_range = 1'b0;
            notify_read_q.insert(notify_read_q.size(), res);
          end
        end
      end
    end
  endtask

  // Input side: a new beat is offered only once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || beat_taken)) begin
      beat_taken = 1'b0;
      if (packet_item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_item = packet_item_q.pop_front();
        mode_i            <= drv_item.mode;
        universe_number_i <= drv_item.uni;
        sequence_number_i <= drv_item.seq;
        slot_index_i      <= drv_item.slot;
        slot_value_i      <= drv_item.val;
        slot_present_i    <= drv_item.present;
        packet_first_i    <= drv_item.first;
        packet_last_i     <= drv_item.last;
        read_address_i    <= drv_item.addr;
        in_valid_i        <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      progress = 1'b0;
      if (in_valid_i && in_ready_o) begin
        absorb_item(drv_item);
        beat_taken = 1'b1;
        progress   = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        progress = 1'b1;
        if (notify_read_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: kind %0d value 0x%02h in_range %0d",
                     result_kind_o, read_value_o, read_in_range_o);
        end else begin
          awaited = notify_read_q.pop_front();
          if (awaited.kind !== result_kind_o || awaited.value !== read_value_o ||
              awaited.in_range !== read_in_range_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected kind %0d value 0x%02h in_range %0d, got %0d 0x%02h %0d",
                       awaited.kind, awaited.value, awaited.in_range,
                       result_kind_o, read_value_o, read_in_range_o);
          end
        end
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a beat", stall_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic dmx_item_t rand_item();
    dmx_item_t   it;
    logic [31:0] r0;
    logic [31:0] r1;
    r0 = $urandom;
    r1 = $urandom;
    it.mode    = ITEM_SLOT;
    it.uni     = r0[15:0];
    it.seq     = r0[23:16];
    it.val     = r0[31:24];
    it.slot    = r1[8:0];
    it.addr    = r1[22:9];
    it.present = r1[23];
    it.first   = r1[24];
    it.last    = r1[25];
    return it;
  endfunction

  function automatic void push_item(input dmx_item_t it);
    packet_item_q.insert(packet_item_q.size(), it);
    items_made++;
  endfunction

  function automatic void direct_slot(input logic [15:0] uni, input logic [7:0] seq,
                                      input logic [8:0] slot, input logic [7:0] val,
                                      input logic present, input logic first,
                                      input logic last);
    dmx_item_t it;
    it = rand_item();
    it.uni     = uni;
    it.seq     = seq;
    it.slot    = slot;
    it.val     = val;
    it.present = present;
    it.first   = first;
    it.last    = last;
    push_item(it);
  endfunction

  function automatic void add_read(input int unsigned a);
    dmx_item_t   it;
    logic [31:0] w;
    it = rand_item();
    w  = a;
    it.mode = ITEM_READ;
    it.addr = w[13:0];
    push_item(it);
  endfunction

  function automatic int unsigned pick_address(input int unsigned cnt);
    int unsigned p;
    int unsigned a;
    p = $urandom_range(0, 9);
    if (p < 5) a = $urandom_range(0, cnt - 1) * SLOTS_PER_UNIVERSE_DEF + $urandom_range(0, 7);
    else if (p < 7) a = eff_chans() * cnt - 1 + $urandom_range(0, 1);
    else a = $urandom_range(0, STORE_DEPTH - 1);
    return a % STORE_DEPTH;
  endfunction

  function automatic int unsigned pick_slots();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return 0;
    if (p < 75) return $urandom_range(1, 4);
    if (p < 95) return $urandom_range(5, 12);
    return $urandom_range(16, 32);
  endfunction

  function automatic void add_packet(input logic [15:0] uni, input logic [7:0] seq,
                                     input int unsigned n, input bit closed);
    int unsigned base;
    logic [31:0] s;
    dmx_item_t   it;
    base = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 7);
    if (n == 0) begin
      it = rand_item();
      it.uni     = uni;
      it.seq     = seq;
      it.present = 1'b0;
      it.first   = 1'b1;
      it.last    = closed;
      push_item(it);
    end else begin
      for (int unsigned k = 0; k < n; k++) begin
        it = rand_item();
        if (k == 0) begin
          it.uni = uni;
          it.seq = seq;
        end
        s = (base + k) % SLOTS_PER_UNIVERSE_DEF;
        it.slot    = s[8:0];
        it.present = ($urandom_range(0, 15) != 0);
        it.first   = (k == 0);
        it.last    = closed && (k == n - 1);
        push_item(it);
      end
    end
  endfunction

  function automatic void random_traffic(input int unsigned n);
    int unsigned target;
    int unsigned rr;
    int unsigned pick;
    int unsigned cnt;
    int unsigned idx;
    int unsigned reps;
    logic [31:0] w;
    logic [31:0] r;
    dmx_item_t   it;
    target = items_made + n;
    rr     = 0;
    while (items_made < target) begin
      pick = $urandom_range(0, 99);
      cnt  = eff_count();
      r    = $urandom;
      if (pick < 50 || (pick >= 88 && pick < 94)) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cnt - 1) : rr % cnt;
        rr++;
        w = sent_seq[idx] + $urandom_range(1, 11);
        sent_seq[idx] = w[7:0];
        w = eff_first() + idx;
        add_packet(w[15:0], sent_seq[idx], pick_slots(), pick < 50);
      end else if (pick < 68) begin
        reps = $urandom_range(1, 4);
        for (int unsigned k = 0; k < reps; k++) add_read(pick_address(cnt));
      end else if (pick < 71) begin
        if (cnt <= 4) begin
          for (int unsigned u = 0; u < cnt; u++)
            for (int unsigned k = 0; k < 8; k++) add_read(u * SLOTS_PER_UNIVERSE_DEF + k);
        end else begin
          add_read(pick_address(cnt));
        end
      end else if (pick < 77) begin
        idx = $urandom_range(0, cnt - 1);
        w   = eff_first() + idx;
        add_packet(w[15:0], sent_seq[idx], pick_slots(), 1'b1);
      end else if (pick < 83) begin
        w = eff_first() + cnt + $urandom_range(0, 65535 - cnt);
        add_packet(w[15:0], r[7:0], pick_slots(), 1'b1);
      end else if (pick < 88) begin
        reps = $urandom_range(1, 3);
        for (int unsigned k = 0; k < reps; k++) begin
          it = rand_item();
          it.first = 1'b0;
          push_item(it);
        end
      end else begin
        it = rand_item();
        it.mode = r[0];
        push_item(it);
      end
    end
  endfunction

  task automatic drain();
    @(negedge clk_i);
    while (packet_item_q.size() != 0 || in_valid_i || notify_read_q.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_FIRST_UNIVERSE: begin
        reg_first = data;
        clear_window();
      end
      CFG_UNIVERSE_COUNT: begin
        reg_count = data[5:0];
        clear_window();
      end
      CFG_CHANNEL_COUNT: reg_chans = data[9:0];
      CFG_SYNC_ENABLE:   reg_sync  = data[0];
      CFG_OUTPUT_MODE:   reg_mode  = data[2:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] first, input logic [5:0] count,
                           input logic [9:0] chans, input logic sync,
                           input logic [2:0] omode);
    drain();
    write_reg(CFG_FIRST_UNIVERSE, first);
    write_reg(CFG_UNIVERSE_COUNT, {10'd0, count});
    write_reg(CFG_CHANNEL_COUNT, {6'd0, chans});
    write_reg(CFG_SYNC_ENABLE, {15'd0, sync});
    write_reg(CFG_OUTPUT_MODE, {13'd0, omode});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      slot_mem[i] = 8'd0;
      snap_mem[i] = 8'd0;
    end
    reg_first      = 16'd1;
    reg_count      = 6'd1;
    reg_chans      = 10'd512;
    reg_sync       = 1'b1;
    reg_mode       = OUT_UPDATE;
    dirty_count    = 0;
    clear_window();
    beat_taken     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    stall_cycles   = 0;
    mismatches     = 0;
    items_made     = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    configure(16'd1, 6'd1, 10'd512, 1'b1, OUT_UPDATE);
    direct_slot(16'd1, 8'd255, 9'd0, 8'hFF, 1'b1, 1'b1, 1'b1);
    direct_slot(16'd1, 8'd0, 9'd0, 8'hFF, 1'b1, 1'b1, 1'b0);
    direct_slot(16'd1, 8'd0, 9'd511, 8'hA5, 1'b1, 1'b0, 1'b0);
    direct_slot(16'd1, 8'd0, 9'd256, 8'h5A, 1'b1, 1'b0, 1'b1);
    direct_slot(16'd1, 8'd0, 9'd7, 8'h11, 1'b1, 1'b1, 1'b1);
    direct_slot(16'd1, 8'd1, 9'd0, 8'h00, 1'b0, 1'b1, 1'b1);
    direct_slot(16'd1, 8'd2, 9'd3, 8'h77, 1'b1, 1'b0, 1'b0);
    direct_slot(16'd2, 8'd2, 9'd3, 8'h77, 1'b1, 1'b1, 1'b1);
    direct_slot(16'd0, 8'd2, 9'd3, 8'h77, 1'b1, 1'b1, 1'b1);
    add_read(0);
    add_read(511);
    add_read(256);
    add_read(512);
    add_read(16383);
    add_read(3);

    configure(16'hFFFF, 6'd3, 10'd0, 1'b1, OUT_CHANGE);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    direct_slot(16'hFFFF, 8'd7, 9'd5, 8'h00, 1'b1, 1'b1, 1'b1);
    direct_slot(16'h0000, 8'd7, 9'd5, 8'h80, 1'b1, 1'b1, 1'b1);
    direct_slot(16'h0001, 8'd7, 9'd5, 8'h00, 1'b1, 1'b1, 1'b1);
    add_read(517);
    direct_slot(16'hFFFF, 8'd8, 9'd6, 8'h00, 1'b1, 1'b1, 1'b1);
    direct_slot(16'h0000, 8'd8, 9'd6, 8'h00, 1'b1, 1'b1, 1'b1);
    direct_slot(16'h0001, 8'd8, 9'd6, 8'h00, 1'b1, 1'b1, 1'b1);
    add_read(2);
    add_read(3);

    configure(16'd1, 6'd1, 10'd512, 1'b1, OUT_UPDATE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(60);

    configure(16'd100, 6'd4, 10'd16, 1'b1, OUT_AUTOMATIC);
    send_idle_pct  = 48;
    recv_stall_pct = 0;
    random_traffic(60);

    configure(16'd63999, 6'd32, 10'd1, 1'b1, OUT_UPDATE);
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    random_traffic(130);

    configure(16'hFFF0, 6'd63, 10'd1023, 1'b0, OUT_CHANGE);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    random_traffic(60);

    configure(16'd0, 6'd0, 10'd0, 1'b1, OUT_BANG);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(40);

    configure(16'd2000, 6'd5, 10'd300, 1'b0, OUT_FORCED);
    send_idle_pct  = 48;
    recv_stall_pct = 0;
    random_traffic(35);

    configure(16'd7, 6'd2, 10'd512, 1'b1, MODE_CODE_7);
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    random_traffic(35);

    configure(16'd300, 6'd3, 10'd100, 1'b1, OUT_CHANGE);
    send_idle_pct  = 12;
    recv_stall_pct = 12;
    random_traffic(35);

    configure(16'd40000, 6'd1, 10'd200, 1'b0, MODE_CODE_5);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_traffic(25);

    // The output side holds off while beats keep coming, so the result queue fills up.
    configure(16'd1, 6'd1, 10'd512, 1'b0, OUT_UPDATE);
    hold_left = HOLD_CYCLES;
    random_traffic(25);
    drain();
    random_traffic(25);

    drain();
    if (mismatches == 0 && notify_read_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
